>>> design/complex_matrix_multiply_top_defines.svh
// ----------------------------------------------------------------------------
// Complex matrix multiply - assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define COMPLEX_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication
`define CMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cmm_pkg.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - package
// Sizes, field widths, codes and shared types.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int VALUE_WIDTH = 16;

  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ENTRY_W   = 2 * VALUE_WIDTH;
  localparam int PROD_W    = 2 * VALUE_WIDTH;
  localparam int TERM_W    = PROD_W + 1;
  localparam int OUT_W     = 37;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RD   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } cmm_state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } cmm_mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } cmm_mac_stat_t;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] lim;
    lim = CFG_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

>>> design/cmm_in_if.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - command channel
// Valid/ready channel carrying element writes and product reads.
// ----------------------------------------------------------------------------
interface cmm_in_if import cmm_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic [MODE_W-1:0]             mode;
  logic [DIM_W-1:0]              row;
  logic [DIM_W-1:0]              col;
  logic signed [VALUE_WIDTH-1:0] value_re;
  logic signed [VALUE_WIDTH-1:0] value_im;

  modport source (output valid, mode, row, col, value_re, value_im, input ready);
  modport sink   (input valid, mode, row, col, value_re, value_im, output ready);

endinterface

>>> design/cmm_out_if.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - result channel
// Valid/ready channel carrying product elements and range status.
// ----------------------------------------------------------------------------
interface cmm_out_if import cmm_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] prod_re;
  logic signed [OUT_W-1:0] prod_im;
  logic                    status;

  modport source (output valid, prod_re, prod_im, status, input ready);
  modport sink   (input valid, prod_re, prod_im, status, output ready);

endinterface

>>> design/cmm_ram.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - element store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/cmm_mac.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - multiply-accumulate unit
// Registered products, registered complex terms, then accumulation.
// ----------------------------------------------------------------------------
module cmm_mac import cmm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmm_mac_ctrl_t           ctrl,
  input  logic [ENTRY_W-1:0]      a_data,
  input  logic [ENTRY_W-1:0]      b_data,
  output cmm_mac_stat_t           stat,
  output logic signed [OUT_W-1:0] acc_re,
  output logic signed [OUT_W-1:0] acc_im
);

  logic signed [VALUE_WIDTH-1:0] a_re, a_im, b_re, b_im;
  logic                          v1, v2, v3;
  logic signed [PROD_W-1:0]      p_rr, p_ii, p_ri, p_ir;
  logic signed [TERM_W-1:0]      t_re, t_im;

  assign a_re = a_data[ENTRY_W-1:VALUE_WIDTH];
  assign a_im = a_data[VALUE_WIDTH-1:0];
  assign b_re = b_data[ENTRY_W-1:VALUE_WIDTH];
  assign b_im = b_data[VALUE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
    end
    if (v2) begin
      t_re <= TERM_W'(p_rr) - TERM_W'(p_ii);
      t_im <= TERM_W'(p_ri) + TERM_W'(p_ir);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v3) begin
      acc_re <= acc_re + OUT_W'(t_re);
      acc_im <= acc_im + OUT_W'(t_im);
    end
  end

  assign stat.busy = v1 | v2 | v3;

endmodule

>>> design/complex_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - top level
// Two complex element stores, a sequencer and one multiply-accumulate unit.
//
//   channel   dir   handshake          payload
//   cfg       in    cfg_we             cfg_index, cfg_data
//   cmd       in    cmd.valid/ready    mode, row, col, value_re, value_im
//   res       out   res.valid/ready    prod_re, prod_im, status
//
// A write leaves the sequencer in idle. A read in range steps through run,
// drain and finish, nk being inner_dim limited to MAX_DIM, with the single
// multiply-accumulate unit taking one inner term per cycle from the two
// store read ports; a read out of range, or with nk zero, skips to finish.
// Reset clears control only; store entries are undefined until written.
// A finished result waits in the output register; a further read completes
// only once that register is free.
// ----------------------------------------------------------------------------
`include "complex_matrix_multiply_top_defines.svh"

module complex_matrix_multiply_top import cmm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  cmm_in_if.sink               cmd,
  cmm_out_if.source            res
);

  logic [CFG_W-1:0]  rows_a, inner_dim, cols_b;
  logic [CFG_W-1:0]  nr, nk, nc;
  cmm_state_t        state, state_next;
  logic [DIM_W-1:0]  row, col, k;
  logic              rd_status;
  logic              xfer, we_a, we_b, rd_oor, load;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [ENTRY_W-1:0] wdata, a_data, b_data;
  cmm_mac_ctrl_t     mac_ctrl;
  cmm_mac_stat_t     mac_stat;
  logic signed [OUT_W-1:0] acc_re, acc_im;
  logic              out_valid;
  logic signed [OUT_W-1:0] out_prod_re, out_prod_im;
  logic              out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign nr = eff_dim(rows_a);
  assign nk = eff_dim(inner_dim);
  assign nc = eff_dim(cols_b);

  assign cmd.ready = (state == S_IDLE);
  assign xfer      = cmd.valid && cmd.ready;

  assign we_a = xfer && (cmd.mode == MODE_WR_A)
                && (CFG_W'(cmd.row) < nr) && (CFG_W'(cmd.col) < nk);
  assign we_b = xfer && (cmd.mode == MODE_WR_B)
                && (CFG_W'(cmd.row) < nk) && (CFG_W'(cmd.col) < nc);
  assign rd_oor = (CFG_W'(cmd.row) >= nr) || (CFG_W'(cmd.col) >= nc);

  assign waddr   = {cmd.row, cmd.col};
  assign wdata   = {cmd.value_re, cmd.value_im};
  assign raddr_a = {row, k};
  assign raddr_b = {k, col};

  assign mac_ctrl.clear = xfer && (cmd.mode == MODE_RD);
  assign mac_ctrl.issue = (state == S_RUN);

  assign load = (state == S_FINISH) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (xfer && (cmd.mode == MODE_RD)) begin
          if (rd_oor || (nk == '0)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (CFG_W'(k) + CFG_W'(1) == nk) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_stat.busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_ctrl.clear) begin
      row       <= cmd.row;
      col       <= cmd.col;
      rd_status <= rd_oor;
      k         <= '0;
    end else if (state == S_RUN) begin
      k <= k + DIM_W'(1);
    end
  end

  cmm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  cmm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  cmm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_data (a_data),
    .b_data (b_data),
    .stat   (mac_stat),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_prod_re <= acc_re;
      out_prod_im <= acc_im;
      out_status  <= rd_status;
    end
  end

  assign res.valid   = out_valid;
  assign res.prod_re = out_prod_re;
  assign res.prod_im = out_prod_im;
  assign res.status  = out_status;

  `CMM_ASSERT_NOW(a_store_write_idle, we_a || we_b, state == S_IDLE,
    "store write outside idle")
  `CMM_ASSERT_NOW(a_mac_quiet_idle, state == S_IDLE, !mac_stat.busy,
    "multiply-accumulate busy while idle")
  `CMM_ASSERT_NOW(a_oor_zero, out_valid && out_status,
    out_prod_re == '0 && out_prod_im == '0, "out-of-range result not zero")
  `CMM_ASSERT_NEXT(a_finish_hold, state == S_FINISH && out_valid && !res.ready,
    state == S_FINISH, "result left while output register full")

endmodule

>>> sim/tb_complex_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Complex matrix multiply - testbench
// Loads complex elements into both stores, requests product elements and
// checks every returned element against an in-bench product calculator or,
// for typed rows, a zero product. The run starts with a short table of
// directed commands, then steps through a series of dimension settings with
// random traffic, under bursty command flow and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb_complex_matrix_multiply_top;
  import cmm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * MAX_DIM + 8;
  localparam int LIMIT_TIME   = 5000000;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic [DIM_W-1:0]              row;
    logic [DIM_W-1:0]              col;
    logic signed [VALUE_WIDTH-1:0] re;
    logic signed [VALUE_WIDTH-1:0] im;
  } elem_cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    status;
  } product_t;

  // typed rows expect a zero product with the given status
  typedef struct packed {
    elem_cmd_t c;
    logic      typed;
    logic      zero_status;
  } table_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cmm_in_if  cmd ();
  cmm_out_if res ();

  complex_matrix_multiply_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res)
  );

  logic signed [VALUE_WIDTH-1:0] a_re [DEPTH];
  logic signed [VALUE_WIDTH-1:0] a_im [DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_re [DEPTH];
  logic signed [VALUE_WIDTH-1:0] b_im [DEPTH];
  bit a_loaded [DEPTH];
  bit b_loaded [DEPTH];
  int n_rows;
  int n_inner;
  int n_cols;

  product_t pending_products [$];

  int  mismatches;
  int  cmds_sent;
  int  reads_sent;
  int  oor_reads;
  int  settings_done;
  int  results_seen;
  int  holds_done;
  int  burst_left;
  int  max_gap;
  bit  hold_req;

  table_row_t directed_rows [22] = '{
    '{'{MODE_WR_A, 4'd0,  4'd0,  16'sh7FFF, 16'sh7FFF}, 1'b0, 1'b0},
    '{'{MODE_WR_A, 4'd0,  4'd1,  16'sh8000, 16'sh8000}, 1'b0, 1'b0},
    '{'{MODE_WR_A, 4'd1,  4'd0,  16'sh0000, 16'sh0000}, 1'b0, 1'b0},
    '{'{MODE_WR_A, 4'd1,  4'd1,  16'sh0000, 16'sh0000}, 1'b0, 1'b0},
    '{'{MODE_WR_B, 4'd0,  4'd0,  16'sh8000, 16'sh7FFF}, 1'b0, 1'b0},
    '{'{MODE_WR_B, 4'd1,  4'd0,  16'sh8000, 16'sh8000}, 1'b0, 1'b0},
    '{'{MODE_WR_B, 4'd0,  4'd1,  16'shFFFF, 16'sh0001}, 1'b0, 1'b0},
    '{'{MODE_WR_B, 4'd1,  4'd1,  16'sh7FFF, 16'sh8000}, 1'b0, 1'b0},
    '{'{MODE_RD,   4'd0,  4'd0,  16'sh0000, 16'sh0000}, 1'b0, 1'b0},
    '{'{MODE_RD,   4'd0,  4'd1,  16'sh0000, 16'sh0000}, 1'b0, 1'b0},
    '{'{MODE_RD,   4'd1,  4'd0,  16'sh0000, 16'sh0000}, 1'b1, 1'b0},
    '{'{MODE_RD,   4'd1,  4'd1,  16'sh0000, 16'sh0000}, 1'b1, 1'b0},
    '{'{MODE_WR_A, 4'd15, 4'd15, 16'sh5555, 16'shAAAA}, 1'b0, 1'b0},
    '{'{MODE_WR_B, 4'd2,  4'd0,  16'shAAAA, 16'sh5555}, 1'b0, 1'b0},
    '{'{MODE_NONE, 4'd1,  4'd1,  16'sh7FFF, 16'sh7FFF}, 1'b0, 1'b0},
    '{'{MODE_RD,   4'd15, 4'd15, 16'sh0000, 16'sh0000}, 1'b1, 1'b1},
    '{'{MODE_RD,   4'd2,  4'd0,  16'sh0000, 16'sh0000}, 1'b1, 1'b1},
    '{'{MODE_RD,   4'd0,  4'd2,  16'sh0000, 16'sh0000}, 1'b1, 1'b1},
    '{'{MODE_RD,   4'd1,  4'd0,  16'sh0000, 16'sh0000}, 1'b1, 1'b0},
    '{'{MODE_RD,   4'd0,  4'd0,  16'sh0000, 16'sh0000}, 1'b0, 1'b0},
    '{'{MODE_WR_A, 4'd0,  4'd0,  16'sh0001, 16'shFFFF}, 1'b0, 1'b0},
    '{'{MODE_RD,   4'd0,  4'd0,  16'sh0000, 16'sh0000}, 1'b0, 1'b0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic product_t product_at(input int r, input int c);
    longint   sum_re;
    longint   sum_im;
    int       ia;
    int       ib;
    product_t p;
    sum_re = 0;
    sum_im = 0;
    p = '0;
    if (r >= n_rows || c >= n_cols) begin
      p.status = 1'b1;
      return p;
    end
    for (int k = 0; k < n_inner; k++) begin
      ia = r * MAX_DIM + k;
      ib = k * MAX_DIM + c;
      sum_re += longint'(a_re[ia]) * longint'(b_re[ib])
              - longint'(a_im[ia]) * longint'(b_im[ib]);
      sum_im += longint'(a_re[ia]) * longint'(b_im[ib])
              + longint'(a_im[ia]) * longint'(b_re[ib]);
    end
    p.re = sum_re[OUT_W-1:0];
    p.im = sum_im[OUT_W-1:0];
    return p;
  endfunction

  function automatic void apply_cmd(input elem_cmd_t c, input bit typed, input bit zero_status);
    int       addr;
    product_t p;
    addr = int'(c.row) * MAX_DIM + int'(c.col);
    case (c.mode)
      MODE_WR_A: begin
        if (c.row < n_rows && c.col < n_inner) begin
          a_re[addr] = c.re;
          a_im[addr] = c.im;
          a_loaded[addr] = 1'b1;
        end
      end
      MODE_WR_B: begin
        if (c.row < n_inner && c.col < n_cols) begin
          b_re[addr] = c.re;
          b_im[addr] = c.im;
          b_loaded[addr] = 1'b1;
        end
      end
      MODE_RD: begin
        if (typed) begin
          p = '0;
          p.status = zero_status;
        end else begin
          p = product_at(c.row, c.col);
        end
        reads_sent++;
        if (p.status) oor_reads++;
        pending_products.push_back(p);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    product_t want;
    if (!rst && res.valid && res.ready) begin
      results_seen++;
      if (pending_products.size() == 0) begin
        report_mismatch("unexpected result prod_re", 0, res.prod_re);
      end else begin
        want = pending_products.pop_front();
        if (res.prod_re !== want.re) report_mismatch("prod_re", want.re, res.prod_re);
        if (res.prod_im !== want.im) report_mismatch("prod_im", want.im, res.prod_im);
        if (res.status !== want.status) report_mismatch("status", want.status, res.status);
      end
    end
  end

  // result consumer: run-length stall pattern, long hold-off on request
  initial begin
    int run_left;
    bit lvl;
    res.ready <= 1'b0;
    run_left = 0;
    lvl = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (run_left == 0) begin
        case ($urandom_range(0, 7))
          0: begin
            lvl = 1'b1;
            run_left = 60;
          end
          1, 2: begin
            lvl = 1'b0;
            run_left = $urandom_range(1, 10);
          end
          default: begin
            lvl = 1'b1;
            run_left = $urandom_range(1, 12);
          end
        endcase
      end
      res.ready <= lvl;
      run_left--;
    end
  end

  task automatic send_item(input elem_cmd_t c, input bit typed = 1'b0,
                           input bit zero_status = 1'b0);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    cmd.valid    <= 1'b1;
    cmd.mode     <= c.mode;
    cmd.row      <= c.row;
    cmd.col      <= c.col;
    cmd.value_re <= c.re;
    cmd.value_im <= c.im;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    burst_left--;
    cmds_sent++;
    apply_cmd(c, typed, zero_status);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_products.size() != 0);
  endtask

  task automatic set_dims(input int r, input int i, input int c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_data  <= CFG_W'(r);
    @(posedge clk);
    cfg_index <= REG_INNER_DIM;
    cfg_data  <= CFG_W'(i);
    @(posedge clk);
    cfg_index <= REG_COLS_B;
    cfg_data  <= CFG_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_rows  = clamp_dim(CFG_W'(r));
    n_inner = clamp_dim(CFG_W'(i));
    n_cols  = clamp_dim(CFG_W'(c));
    settings_done++;
  endtask

  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic elem_cmd_t make_cmd(input logic [MODE_W-1:0] m, input int r, input int c);
    elem_cmd_t e;
    e.mode = m;
    e.row  = DIM_W'(r);
    e.col  = DIM_W'(c);
    e.re   = rand_value();
    e.im   = rand_value();
    return e;
  endfunction

  task automatic run_phase(input int r, input int i, input int c, input int count,
                           input bit with_hold, input int gap_max);
    int pick;
    int rr;
    int cc;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    set_dims(r, i, c);
    max_gap = gap_max;
    // load every in-range element not yet written
    for (int x = 0; x < n_rows; x++)
      for (int k = 0; k < n_inner; k++)
        if (!a_loaded[x * MAX_DIM + k]) send_item(make_cmd(MODE_WR_A, x, k));
    for (int k = 0; k < n_inner; k++)
      for (int y = 0; y < n_cols; y++)
        if (!b_loaded[k * MAX_DIM + y]) send_item(make_cmd(MODE_WR_B, k, y));
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 4) hold_req = 1'b1;
      if (n == count / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        rr = (n_rows > 0) ? $urandom_range(0, n_rows - 1) : $urandom_range(0, MAX_DIM - 1);
        cc = (n_cols > 0) ? $urandom_range(0, n_cols - 1) : $urandom_range(0, MAX_DIM - 1);
        send_item(make_cmd(MODE_RD, rr, cc));
      end else if (pick < 65 && n_rows > 0 && n_inner > 0) begin
        send_item(make_cmd(MODE_WR_A, $urandom_range(0, n_rows - 1),
                           $urandom_range(0, n_inner - 1)));
      end else if (pick < 85 && n_inner > 0 && n_cols > 0) begin
        send_item(make_cmd(MODE_WR_B, $urandom_range(0, n_inner - 1),
                           $urandom_range(0, n_cols - 1)));
      end else begin
        send_item(make_cmd(MODE_W'($urandom_range(0, 3)), $urandom_range(0, MAX_DIM - 1),
                           $urandom_range(0, MAX_DIM - 1)));
      end
    end
  endtask

  initial begin
    #(LIMIT_TIME);
    $display("Timeout with %0d results outstanding", pending_products.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ROWS_A;
    cfg_data     <= '0;
    cmd.valid    <= 1'b0;
    cmd.mode     <= MODE_WR_A;
    cmd.row      <= '0;
    cmd.col      <= '0;
    cmd.value_re <= '0;
    cmd.value_im <= '0;
    hold_req = 1'b0;
    burst_left = 0;
    max_gap = 4;
    n_rows  = clamp_dim(DIM_RESET);
    n_inner = clamp_dim(DIM_RESET);
    n_cols  = clamp_dim(DIM_RESET);
    foreach (a_loaded[i]) begin
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_dims(2, 2, 2);
    foreach (directed_rows[i])
      send_item(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].zero_status);

    run_phase(3, 5, 4, 120, 1'b0, 6);
    run_phase(16, 16, 16, 220, 1'b1, 8);
    run_phase(0, 16, 16, 60, 1'b0, 4);
    run_phase(16, 0, 16, 60, 1'b0, 4);
    run_phase(31, 31, 31, 150, 1'b0, 6);
    run_phase(1, 16, 1, 100, 1'b0, 3);
    run_phase(16, 1, 16, 100, 1'b0, 6);
    run_phase(7, 3, 11, 120, 1'b0, 8);
    run_phase(17, 2, 0, 60, 1'b0, 4);
    run_phase(2, 16, 9, 120, 1'b0, 5);
    run_phase(16, 16, 16, 150, 1'b0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands over %0d dimension settings, %0d of them product reads",
             cmds_sent, settings_done, reads_sent);
    $display("Checked %0d results (%0d out of range), %0d consumer hold-offs",
             results_seen, oor_reads, holds_done);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
